[src/ebms_pkg.sv]
// Shared types, codes and reset constants for the ESC bus master sequencer.
`timescale 1ns / 1ps

package ebms_pkg;

    localparam int TIME_BITS_DEF = 32;

    // bus phases
    localparam logic [1:0] PH_STARTUP   = 2'd0;
    localparam logic [1:0] PH_HANDSHAKE = 2'd1;
    localparam logic [1:0] PH_RUNNING   = 2'd2;

    // send kinds
    localparam logic [1:0] SEND_NONE    = 2'd0;
    localparam logic [1:0] SEND_HS      = 2'd1;
    localparam logic [1:0] SEND_CHANNEL = 2'd2;

    // input operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // received frame types
    localparam logic [1:0] FT_HANDSHAKE = 2'd0;
    localparam logic [1:0] FT_TELEMETRY = 2'd1;

    localparam logic [6:0] HS_MIN_LEN   = 7'd14;
    localparam logic [6:0] TLM_MIN_LEN  = 7'd22;
    localparam logic [7:0] BROADCAST_ID = 8'hFF;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STARTUP_DELAY = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HS_STEP       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISC_RETRY    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHAN_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINK_TIMEOUT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ESC_ID_MIN    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ESC_ID_MAX    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MASTER_ID     = 3'd7;
    localparam int CFG_DATA_BITS = 16;

    // configuration reset values
    localparam logic [15:0] STARTUP_DELAY_RST = 16'd50;
    localparam logic [15:0] HS_STEP_RST       = 16'd8;
    localparam logic [15:0] DISC_RETRY_RST    = 16'd300;
    localparam logic [15:0] CHAN_PERIOD_RST   = 16'd11;
    localparam logic [15:0] LINK_TIMEOUT_RST  = 16'd2000;
    localparam logic [7:0]  ESC_ID_MIN_RST    = 8'd64;
    localparam logic [7:0]  ESC_ID_MAX_RST    = 8'd79;
    localparam logic [7:0]  MASTER_ID_RST     = 8'd33;

    typedef struct packed {
        logic [15:0] startup_wait_ms;
        logic [15:0] hs_gap_ms;
        logic [15:0] discovery_retry_ms;
        logic [15:0] chan_gap_ms;
        logic [15:0] link_timeout_ms;
        logic [7:0]  esc_id_min;
        logic [7:0]  esc_id_max;
        logic [7:0]  master_id;
    } t_cfg;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic        frame_valid;
        logic [1:0]  frame_type;
        logic [6:0]  frame_length;
        logic [7:0]  header_byte3;
        logic [7:0]  header_byte4;
        logic        failsafe;
        logic [15:0] throttle_code;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [7:0]  target_id;
        logic [15:0] throttle_out;
        logic        failsafe_out;
        logic        bus_reset;
        logic [1:0]  bus_phase;
    } t_out_word;

endpackage

[src/ebms_cfg.sv]
// Configuration register file with reset defaults.
`timescale 1ns / 1ps

module ebms_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ebms_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ebms_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output ebms_pkg::t_cfg                      o_cfg
);

    ebms_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_wait_ms    <= ebms_pkg::STARTUP_DELAY_RST;
            r_cfg.hs_gap_ms          <= ebms_pkg::HS_STEP_RST;
            r_cfg.discovery_retry_ms <= ebms_pkg::DISC_RETRY_RST;
            r_cfg.chan_gap_ms        <= ebms_pkg::CHAN_PERIOD_RST;
            r_cfg.link_timeout_ms    <= ebms_pkg::LINK_TIMEOUT_RST;
            r_cfg.esc_id_min         <= ebms_pkg::ESC_ID_MIN_RST;
            r_cfg.esc_id_max         <= ebms_pkg::ESC_ID_MAX_RST;
            r_cfg.master_id          <= ebms_pkg::MASTER_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ebms_pkg::CFG_STARTUP_DELAY: r_cfg.startup_wait_ms    <= i_cfg_wdata;
                ebms_pkg::CFG_HS_STEP:       r_cfg.hs_gap_ms          <= i_cfg_wdata;
                ebms_pkg::CFG_DISC_RETRY:    r_cfg.discovery_retry_ms <= i_cfg_wdata;
                ebms_pkg::CFG_CHAN_PERIOD:   r_cfg.chan_gap_ms        <= i_cfg_wdata;
                ebms_pkg::CFG_LINK_TIMEOUT:  r_cfg.link_timeout_ms    <= i_cfg_wdata;
                ebms_pkg::CFG_ESC_ID_MIN:    r_cfg.esc_id_min         <= i_cfg_wdata[7:0];
                ebms_pkg::CFG_ESC_ID_MAX:    r_cfg.esc_id_max         <= i_cfg_wdata[7:0];
                ebms_pkg::CFG_MASTER_ID:     r_cfg.master_id          <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/ebms_step.sv]
// Sequencer state and the combinational step logic for one word.
`timescale 1ns / 1ps

module ebms_step #(
    parameter int TIME_BITS = ebms_pkg::TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ebms_pkg::t_in_word  i_word,
    input  ebms_pkg::t_cfg      i_cfg,
    output ebms_pkg::t_out_word o_res
);

    logic [1:0]           r_phase,      n_phase;
    logic [TIME_BITS-1:0] r_phase_t0,   n_phase_t0;
    logic [TIME_BITS-1:0] r_last_send,  n_last_send;
    logic [TIME_BITS-1:0] r_last_rx,    n_last_rx;
    logic [7:0]           r_scan_id,    n_scan_id;
    logic [7:0]           r_esc_id,     n_esc_id;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] el_phase, el_send, el_rx;
    logic                 do_reset;
    ebms_pkg::t_out_word  res;

    assign now_t    = i_word.now_ms[TIME_BITS-1:0];
    assign el_phase = now_t - r_phase_t0;
    assign el_send  = now_t - r_last_send;
    assign el_rx    = now_t - r_last_rx;

    always_comb begin
        n_phase     = r_phase;
        n_phase_t0  = r_phase_t0;
        n_last_send = r_last_send;
        n_last_rx   = r_last_rx;
        n_scan_id   = r_scan_id;
        n_esc_id    = r_esc_id;
        do_reset    = 1'b0;
        res         = '0;

        if (i_word.operation == ebms_pkg::OP_FRAME) begin
            if (i_word.frame_valid) begin
                n_last_rx = now_t;
                if (i_word.frame_type == ebms_pkg::FT_HANDSHAKE &&
                    i_word.frame_length >= ebms_pkg::HS_MIN_LEN) begin
                    if (i_word.header_byte3 >= i_cfg.esc_id_min &&
                        i_word.header_byte3 <= i_cfg.esc_id_max &&
                        (i_word.header_byte4 == i_cfg.master_id ||
                         i_word.header_byte4 == 8'd0)) begin
                        n_esc_id = i_word.header_byte3;
                    end
                end else if (i_word.frame_type == ebms_pkg::FT_TELEMETRY &&
                             i_word.frame_length >= ebms_pkg::TLM_MIN_LEN) begin
                    // telemetry to broadcast means the ESC restarted
                    if (i_word.header_byte3 == ebms_pkg::BROADCAST_ID) begin
                        do_reset = 1'b1;
                    end
                end
            end
        end else begin
            unique case (r_phase)
                ebms_pkg::PH_HANDSHAKE: begin
                    if (el_send >= TIME_BITS'(i_cfg.hs_gap_ms)) begin
                        res.send_kind = ebms_pkg::SEND_HS;
                        n_last_send   = now_t;
                        if (r_scan_id < i_cfg.esc_id_max) begin
                            n_scan_id     = r_scan_id + 8'd1;
                            res.target_id = r_scan_id + 8'd1;
                        end else begin
                            res.target_id = ebms_pkg::BROADCAST_ID;
                            n_phase       = ebms_pkg::PH_RUNNING;
                            n_phase_t0    = now_t;
                        end
                    end
                end
                ebms_pkg::PH_RUNNING: begin
                    if (r_esc_id == 8'd0 &&
                        el_phase >= TIME_BITS'(i_cfg.discovery_retry_ms)) begin
                        do_reset = 1'b1;
                    end else if (!i_word.failsafe && r_last_rx != '0 &&
                                 el_rx >= TIME_BITS'(i_cfg.link_timeout_ms)) begin
                        do_reset = 1'b1;
                    end else if (r_last_send == '0 ||
                                 el_send >= TIME_BITS'(i_cfg.chan_gap_ms)) begin
                        res.send_kind    = ebms_pkg::SEND_CHANNEL;
                        res.target_id    = r_esc_id;
                        res.throttle_out = i_word.failsafe ? 16'd0 : i_word.throttle_code;
                        res.failsafe_out = i_word.failsafe;
                        n_last_send      = now_t;
                    end
                end
                default: begin
                    // startup, and the unused code too
                    if (el_phase >= TIME_BITS'(i_cfg.startup_wait_ms)) begin
                        n_phase       = ebms_pkg::PH_HANDSHAKE;
                        n_phase_t0    = now_t;
                        n_scan_id     = i_cfg.esc_id_min;
                        res.send_kind = ebms_pkg::SEND_HS;
                        res.target_id = i_cfg.esc_id_min;
                        n_last_send   = now_t;
                    end
                end
            endcase
        end

        if (do_reset) begin
            n_phase     = ebms_pkg::PH_STARTUP;
            n_phase_t0  = now_t;
            n_last_send = '0;
            n_last_rx   = '0;
            n_scan_id   = i_cfg.esc_id_min;
            n_esc_id    = 8'd0;
        end

        res.bus_reset = do_reset;
        res.bus_phase = (n_phase == ebms_pkg::PH_HANDSHAKE ||
                         n_phase == ebms_pkg::PH_RUNNING) ? n_phase : ebms_pkg::PH_STARTUP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ebms_pkg::PH_STARTUP;
            r_phase_t0  <= '0;
            r_last_send <= '0;
            r_last_rx   <= '0;
            r_scan_id   <= ebms_pkg::ESC_ID_MIN_RST;
            r_esc_id    <= 8'd0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_phase_t0  <= n_phase_t0;
            r_last_send <= n_last_send;
            r_last_rx   <= n_last_rx;
            r_scan_id   <= n_scan_id;
            r_esc_id    <= n_esc_id;
        end
    end

    assign o_res = res;

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.bus_reset |->
            res.send_kind == ebms_pkg::SEND_NONE && res.bus_phase == ebms_pkg::PH_STARTUP)
        else $error("bus reset word carries a send or a non-startup phase");

    a_chan_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.send_kind == ebms_pkg::SEND_CHANNEL |->
            r_phase == ebms_pkg::PH_RUNNING && res.bus_phase == ebms_pkg::PH_RUNNING)
        else $error("channel frame outside running phase");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.bus_reset |=>
            r_esc_id == 8'd0 && r_last_send == '0 && r_last_rx == '0)
        else $error("bus reset left discovery or time stamps set");

    // scan at the top of its range: the broadcast ends the handshake phase
    a_bcast_enters_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase == ebms_pkg::PH_HANDSHAKE &&
        r_scan_id >= i_cfg.esc_id_max &&
        res.send_kind == ebms_pkg::SEND_HS &&
        res.target_id == ebms_pkg::BROADCAST_ID |=> r_phase == ebms_pkg::PH_RUNNING)
        else $error("broadcast handshake did not enter running");

endmodule

[src/esc_bus_master_sequencer.sv]
// Top level: input word register, step logic, result word register, config port.
// An accepted word is held in the input reg, the step logic works on it and its result is
// registered in the result reg. Throughput: one word per cycle while the result does not
// stall; the step is a few 32-bit subtracts and compares.
// A stalled result holds in the output register while one more word waits at the input.
// Reset (i_rst_n low, synchronous): phase startup, time stamps zero, scan at
// the default first ID, config registers at their defaults, both stages empty.
`timescale 1ns / 1ps

module esc_bus_master_sequencer #(
    parameter int TIME_BITS = ebms_pkg::TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ebms_pkg::t_in_word                  i_in_word,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ebms_pkg::t_out_word                 o_out_word,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [ebms_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ebms_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata
);

    logic                r_in_valid;
    ebms_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    ebms_pkg::t_out_word r_out_word;

    logic                out_free;   // result reg can take a new word
    logic                step_fire;  // input reg word is processed this cycle
    logic                in_take;
    ebms_pkg::t_cfg      cfg;
    ebms_pkg::t_out_word step_res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step_fire  = r_in_valid && out_free;
    // input reg refills when empty or when its word moves on
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out_word <= step_res;
        end
    end

    ebms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ebms_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (step_fire),
        .i_word  (r_in_word),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
